>>> design/spp_pkg.sv
package spp_pkg;

   localparam int CHANNELS   = 4;
   localparam int TIMER_BITS = 16;
   localparam int STAGE_BITS = 2;
   localparam int CMD_BITS   = 2 * CHANNELS;
   localparam int CFG_BITS   = 16;

   typedef logic [CHANNELS-1:0]   chan_type;
   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [STAGE_BITS-1:0] stage_type;
   typedef logic [CFG_BITS-1:0]   cfg_word_type;

   // per-channel command codes
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_ON      = 2'd1;
   localparam logic [1:0] CMD_OFF     = 2'd2;
   localparam logic [1:0] CMD_INVALID = 2'd3;

   // item kinds
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   // register indexes (byte address 4*i)
   localparam logic [1:0] REG_STAGE_ONE   = 2'd0;
   localparam logic [1:0] REG_STAGE_TWO   = 2'd1;
   localparam logic [1:0] REG_STAGE_THREE = 2'd2;
   localparam logic [1:0] REG_MONITOR     = 2'd3;

   localparam cfg_word_type STAGE_DELAY_RESET = 16'd1000;
   localparam cfg_word_type MONITOR_RESET     = 16'd500;

   typedef struct packed {
      cfg_word_type stage_one_delay_ms;
      cfg_word_type stage_two_delay_ms;
      cfg_word_type stage_three_delay_ms;
      cfg_word_type monitor_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic                kind;
      logic [CMD_BITS-1:0] channel_commands;
      chan_type            channel_feedback;
      logic                relay_driver_error;
   } req_item_type;

   typedef struct packed {
      chan_type  relay_on_mask;
      logic [1:0] pump_state;
      stage_type start_stage;
      logic      fault_event;
      logic      feedback_changed;
   } rsp_item_type;

   // ones in the lowest n channel positions
   function automatic chan_type low_mask(input logic [STAGE_BITS:0] n);
      chan_type m;
      for (int i = 0; i < CHANNELS; i++) begin
         m[i] = ((STAGE_BITS+1)'(i) < n);
      end
      return m;
   endfunction

endpackage

>>> design/spp_channels.sv
interface spp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [spp_pkg::CMD_BITS-1:0]  channel_commands;
   logic [spp_pkg::CHANNELS-1:0]  channel_feedback;
   logic                          relay_driver_error;

   modport source (
      output valid, kind, channel_commands, channel_feedback, relay_driver_error,
      input  ready
   );
   modport sink (
      input  valid, kind, channel_commands, channel_feedback, relay_driver_error,
      output ready
   );
endinterface

interface spp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spp_pkg::CHANNELS-1:0]  relay_on_mask;
   logic [1:0]                    pump_state;
   logic [spp_pkg::STAGE_BITS-1:0] start_stage;
   logic                          fault_event;
   logic                          feedback_changed;

   modport source (
      output valid, relay_on_mask, pump_state, start_stage, fault_event,
             feedback_changed,
      input  ready
   );
   modport sink (
      input  valid, relay_on_mask, pump_state, start_stage, fault_event,
             feedback_changed,
      output ready
   );
endinterface

>>> design/spp_csr.sv
module spp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output spp_pkg::cfg_type cfg
);

   spp_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_one_delay_ms   <= spp_pkg::STAGE_DELAY_RESET;
         cfg_ff.stage_two_delay_ms   <= spp_pkg::STAGE_DELAY_RESET;
         cfg_ff.stage_three_delay_ms <= spp_pkg::STAGE_DELAY_RESET;
         cfg_ff.monitor_interval_ms  <= spp_pkg::MONITOR_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            spp_pkg::REG_STAGE_ONE:   cfg_ff.stage_one_delay_ms   <= csr_pwdata[15:0];
            spp_pkg::REG_STAGE_TWO:   cfg_ff.stage_two_delay_ms   <= csr_pwdata[15:0];
            spp_pkg::REG_STAGE_THREE: cfg_ff.stage_three_delay_ms <= csr_pwdata[15:0];
            spp_pkg::REG_MONITOR:     cfg_ff.monitor_interval_ms  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         spp_pkg::REG_STAGE_ONE:   csr_prdata = {16'd0, cfg_ff.stage_one_delay_ms};
         spp_pkg::REG_STAGE_TWO:   csr_prdata = {16'd0, cfg_ff.stage_two_delay_ms};
         spp_pkg::REG_STAGE_THREE: csr_prdata = {16'd0, cfg_ff.stage_three_delay_ms};
         spp_pkg::REG_MONITOR:     csr_prdata = {16'd0, cfg_ff.monitor_interval_ms};
         default:                  csr_prdata = 32'd0;
      endcase
   end

endmodule

>>> design/spp_core.sv
module spp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  spp_pkg::req_item_type item,
   input  spp_pkg::cfg_type      cfg,
   output spp_pkg::rsp_item_type result
);

   typedef enum logic [1:0] {
      PH_STOPPED  = 2'd0,
      PH_STARTING = 2'd1,
      PH_RUNNING  = 2'd2,
      PH_FAULT    = 2'd3
   } phase_type;

   localparam spp_pkg::stage_type LAST_STAGE = spp_pkg::STAGE_BITS'(spp_pkg::CHANNELS - 1);
   localparam spp_pkg::timer_type TIMER_MAX  = '1;

   phase_type           phase_ff,   phase_in;
   spp_pkg::stage_type  stage_ff,   stage_in;
   spp_pkg::timer_type  stage_el_ff, stage_el_in;
   spp_pkg::timer_type  mon_el_ff,  mon_el_in;
   spp_pkg::chan_type   relay_ff,   relay_in;
   spp_pkg::chan_type   last_fb_ff;

   spp_pkg::timer_type  stage_el_inc;
   spp_pkg::timer_type  mon_el_inc;
   spp_pkg::timer_type  stage_wait;
   spp_pkg::stage_type  stage_next;
   logic [spp_pkg::STAGE_BITS:0] stage_count;
   logic                bad_cmd;
   logic                any_on;
   logic                any_off;
   logic                fault;
   logic [1:0]          code;

   assign stage_el_inc = (stage_el_ff == TIMER_MAX) ? stage_el_ff : stage_el_ff + 1'b1;
   assign mon_el_inc   = (mon_el_ff == TIMER_MAX) ? mon_el_ff : mon_el_ff + 1'b1;
   assign stage_next   = stage_ff + 1'b1;
   assign stage_count  = {1'b0, stage_ff} + 1'b1;

   // last stage waits one monitor interval
   always_comb begin
      if (stage_ff == LAST_STAGE) begin
         stage_wait = cfg.monitor_interval_ms;
      end else begin
         case (stage_ff)
            2'd0:    stage_wait = cfg.stage_one_delay_ms;
            2'd1:    stage_wait = cfg.stage_two_delay_ms;
            default: stage_wait = cfg.stage_three_delay_ms;
         endcase
      end
   end

   always_comb begin
      bad_cmd = 1'b0;
      any_on  = 1'b0;
      any_off = 1'b0;
      code    = spp_pkg::CMD_NONE;
      for (int c = 0; c < spp_pkg::CHANNELS; c++) begin
         code = item.channel_commands[2*c +: 2];
         if (code == spp_pkg::CMD_INVALID) bad_cmd = 1'b1;
         else if (code == spp_pkg::CMD_OFF) any_off = 1'b1;
         else if (code == spp_pkg::CMD_ON)  any_on  = 1'b1;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      stage_in    = stage_ff;
      stage_el_in = stage_el_ff;
      mon_el_in   = mon_el_ff;
      relay_in    = relay_ff;
      fault       = 1'b0;

      if (item.kind == spp_pkg::KIND_COMMAND) begin
         if (!bad_cmd) begin
            if (any_off) begin
               phase_in    = PH_STOPPED;
               relay_in    = '0;
               stage_in    = '0;
               stage_el_in = '0;
               mon_el_in   = '0;
            end else if (any_on && phase_ff != PH_STARTING && phase_ff != PH_RUNNING) begin
               stage_in    = '0;
               stage_el_in = '0;
               mon_el_in   = '0;
               if (item.relay_driver_error) begin
                  phase_in = PH_FAULT;
                  relay_in = '0;
                  fault    = 1'b1;
               end else begin
                  phase_in = PH_STARTING;
                  relay_in = spp_pkg::CHANNELS'(1);
               end
            end
         end
      end else begin
         case (phase_ff)
            PH_STARTING: begin
               stage_el_in = stage_el_inc;
               mon_el_in   = mon_el_inc;
               if (stage_el_inc >= stage_wait) begin
                  if ((item.channel_feedback & spp_pkg::low_mask(stage_count))
                      != spp_pkg::low_mask(stage_count)) begin
                     fault = 1'b1;
                  end else if (stage_ff == LAST_STAGE) begin
                     phase_in    = PH_RUNNING;
                     stage_in    = '0;
                     stage_el_in = '0;
                     mon_el_in   = '0;
                  end else if (item.relay_driver_error) begin
                     fault = 1'b1;
                  end else begin
                     relay_in    = relay_ff | (spp_pkg::CHANNELS'(1) << stage_next);
                     stage_in    = stage_next;
                     stage_el_in = '0;
                     mon_el_in   = '0;
                  end
               end else if (mon_el_inc >= cfg.monitor_interval_ms) begin
                  mon_el_in = '0;
                  if ((item.channel_feedback & spp_pkg::low_mask({1'b0, stage_ff}))
                      != spp_pkg::low_mask({1'b0, stage_ff})) begin
                     fault = 1'b1;
                  end
               end
            end
            PH_RUNNING: begin
               mon_el_in = mon_el_inc;
               if (mon_el_inc >= cfg.monitor_interval_ms) begin
                  mon_el_in = '0;
                  if (item.channel_feedback != '1) fault = 1'b1;
               end
            end
            default: ;
         endcase
         // drop every relay on a feedback or driver fault
         if (fault) begin
            phase_in    = PH_FAULT;
            relay_in    = '0;
            stage_in    = '0;
            stage_el_in = '0;
            mon_el_in   = '0;
         end
      end
   end

   assign result.relay_on_mask    = relay_in;
   assign result.pump_state       = phase_in;
   assign result.start_stage      = (phase_in == PH_STARTING) ? stage_in : '0;
   assign result.fault_event      = fault;
   assign result.feedback_changed = (item.channel_feedback != last_fb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STOPPED;
         stage_ff    <= '0;
         stage_el_ff <= '0;
         mon_el_ff   <= '0;
         relay_ff    <= '0;
         last_fb_ff  <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         stage_ff    <= stage_in;
         stage_el_ff <= stage_el_in;
         mon_el_ff   <= mon_el_in;
         relay_ff    <= relay_in;
         last_fb_ff  <= item.channel_feedback;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_relays_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOPPED || phase_ff == PH_FAULT) |-> relay_ff == '0)
      else $error("relays on while stopped or faulted");

   a_running_all_on: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RUNNING |-> relay_ff == '1)
      else $error("running without all relays on");

   a_starting_mask: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STARTING |-> relay_ff == spp_pkg::low_mask(stage_count))
      else $error("relay mask does not match start stage");

   a_fault_event_state: assert property (@(posedge clock) disable iff (reset)
      (fire && result.fault_event) |=> phase_ff == PH_FAULT && relay_ff == '0)
      else $error("fault event without fault shutdown");

   a_stage_idle_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_STARTING |-> stage_ff == '0)
      else $error("stage index set outside start sequence");
`endif

endmodule

>>> design/staged_pump_start_sequencer.sv
// Channel | Dir | Handshake   | Beat payload
// --------+-----+-------------+----------------------------------------------------------
// req     | in  | valid/ready | kind, channel_commands, channel_feedback, relay_driver_error
// rsp     | out | valid/ready | relay_on_mask, pump_state, start_stage, fault_event,
//         |     |             | feedback_changed
// csr     | in  | APB write   | four 16-bit delay registers at byte address 4*i
//
// One rsp beat per req beat, one req beat per cycle sustained while rsp is
// ready. Each beat passes an input register, then the sequencer update and
// result register. Reset is synchronous and returns to stopped with all
// relays off and the registers at their defaults. Stalls on rsp hold the
// result register; req.ready drops while the input register holds a beat that cannot advance.
module staged_pump_start_sequencer (
   input  logic        clock,
   input  logic        reset,
   spp_req_if.sink     req,
   spp_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   spp_pkg::cfg_type      cfg;
   spp_pkg::req_item_type in_item_ff;
   spp_pkg::rsp_item_type out_item_ff;
   spp_pkg::rsp_item_type result;
   logic                  in_vld_ff,  in_vld_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  fire;
   logic                  req_take;

   spp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance a held beat whenever the result register is free or draining
   assign fire      = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || fire;
   assign req_take  = req.valid && req.ready;

   assign in_vld_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
   assign out_vld_in = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);

   spp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers: capture the req beat, hold the rsp beat while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind               <= req.kind;
         in_item_ff.channel_commands   <= req.channel_commands;
         in_item_ff.channel_feedback   <= req.channel_feedback;
         in_item_ff.relay_driver_error <= req.relay_driver_error;
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.relay_on_mask    = out_item_ff.relay_on_mask;
   assign rsp.pump_state       = out_item_ff.pump_state;
   assign rsp.start_stage      = out_item_ff.start_stage;
   assign rsp.fault_event      = out_item_ff.fault_event;
   assign rsp.feedback_changed = out_item_ff.feedback_changed;

endmodule

>>> bench/spp_status_checker.sv
`timescale 1ns / 1ps

module spp_status_checker
   import spp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spp_req_if          req,
   spp_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          pending
);

   typedef enum logic [1:0] {
      PUMP_STOPPED  = 2'd0,
      PUMP_STARTING = 2'd1,
      PUMP_RUNNING  = 2'd2,
      PUMP_FAULT    = 2'd3
   } pump_phase_type;

   // starter state and register copy
   cfg_type        cfg;
   pump_phase_type phase;
   stage_type      stage;
   timer_type      stage_ms;
   timer_type      monitor_ms;
   chan_type       relays;
   chan_type       last_fb;

   rsp_item_type   expected_status[$];
   rsp_item_type   want;
   rsp_item_type   seen;
   req_item_type   taken;
   int             results_seen;

   task automatic report(input string what, input int got, input int exp);
      $display("%0t mismatch on result %0d: %s got %0h expected %0h",
               $realtime, results_seen, what, got, exp);
      mismatches++;
   endtask

   function automatic logic all_on(input chan_type fb, input int n);
      for (int i = 0; i < CHANNELS; i++) begin
         if (i < n && !fb[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // registers are as wide as the timers, so no clipping is needed
   function automatic timer_type stage_wait(input stage_type k);
      if (int'(k) + 1 >= CHANNELS) return cfg.monitor_interval_ms;
      if (k == 0) return cfg.stage_one_delay_ms;
      if (k == 1) return cfg.stage_two_delay_ms;
      return cfg.stage_three_delay_ms;
   endfunction

   function automatic void shut_down(input pump_phase_type p);
      relays     = '0;
      phase      = p;
      stage      = '0;
      stage_ms   = '0;
      monitor_ms = '0;
   endfunction

   // returns 1 when the driver error trips the fault
   function automatic logic engage_stage(input stage_type k, input logic drv_err);
      if (drv_err) begin
         shut_down(PUMP_FAULT);
         return 1'b1;
      end
      relays[k]  = 1'b1;
      phase      = PUMP_STARTING;
      stage      = k;
      stage_ms   = '0;
      monitor_ms = '0;
      return 1'b0;
   endfunction

   function automatic rsp_item_type advance_starter(input req_item_type it);
      rsp_item_type r;
      logic         fault;
      logic         bad;
      logic         any_on;
      logic         any_off;
      logic [1:0]   code;
      fault  = 1'b0;
      r.feedback_changed = (it.channel_feedback != last_fb);
      last_fb = it.channel_feedback;
      if (it.kind == KIND_COMMAND) begin
         bad     = 1'b0;
         any_on  = 1'b0;
         any_off = 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            code = it.channel_commands[2*c +: 2];
            if (code == CMD_INVALID) bad = 1'b1;
            else if (code == CMD_OFF) any_off = 1'b1;
            else if (code == CMD_ON) any_on = 1'b1;
         end
         if (!bad) begin
            if (any_off) begin
               shut_down(PUMP_STOPPED);
            end else if (any_on && phase != PUMP_STARTING && phase != PUMP_RUNNING) begin
               relays = '0;
               fault  = engage_stage('0, it.relay_driver_error);
            end
         end
      end else if (phase == PUMP_STARTING) begin
         if (stage_ms != '1) stage_ms++;
         if (monitor_ms != '1) monitor_ms++;
         if (stage_ms >= stage_wait(stage)) begin
            if (!all_on(it.channel_feedback, int'(stage) + 1)) begin
               shut_down(PUMP_FAULT);
               fault = 1'b1;
            end else if (int'(stage) + 1 >= CHANNELS) begin
               phase      = PUMP_RUNNING;
               stage      = '0;
               stage_ms   = '0;
               monitor_ms = '0;
            end else begin
               fault = engage_stage(stage + 1'b1, it.relay_driver_error);
            end
         end else if (monitor_ms >= cfg.monitor_interval_ms) begin
            monitor_ms = '0;
            if (!all_on(it.channel_feedback, int'(stage))) begin
               shut_down(PUMP_FAULT);
               fault = 1'b1;
            end
         end
      end else if (phase == PUMP_RUNNING) begin
         if (monitor_ms != '1) monitor_ms++;
         if (monitor_ms >= cfg.monitor_interval_ms) begin
            monitor_ms = '0;
            if (!all_on(it.channel_feedback, CHANNELS)) begin
               shut_down(PUMP_FAULT);
               fault = 1'b1;
            end
         end
      end
      r.relay_on_mask = relays;
      r.pump_state    = phase;
      r.start_stage   = (phase == PUMP_STARTING) ? stage : '0;
      r.fault_event   = fault;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.stage_one_delay_ms   = STAGE_DELAY_RESET;
         cfg.stage_two_delay_ms   = STAGE_DELAY_RESET;
         cfg.stage_three_delay_ms = STAGE_DELAY_RESET;
         cfg.monitor_interval_ms  = MONITOR_RESET;
         shut_down(PUMP_STOPPED);
         last_fb = '0;
         expected_status.delete();
         results_seen = 0;
         mismatches   = 0;
         pending     <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_STAGE_ONE:   cfg.stage_one_delay_ms   = csr_pwdata[CFG_BITS-1:0];
               REG_STAGE_TWO:   cfg.stage_two_delay_ms   = csr_pwdata[CFG_BITS-1:0];
               REG_STAGE_THREE: cfg.stage_three_delay_ms = csr_pwdata[CFG_BITS-1:0];
               REG_MONITOR:     cfg.monitor_interval_ms  = csr_pwdata[CFG_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            seen.relay_on_mask    = rsp.relay_on_mask;
            seen.pump_state       = rsp.pump_state;
            seen.start_stage      = rsp.start_stage;
            seen.fault_event      = rsp.fault_event;
            seen.feedback_changed = rsp.feedback_changed;
            if (expected_status.size() == 0) begin
               report("result with nothing expected", seen, 0);
            end else begin
               want = expected_status.pop_front();
               if (seen.relay_on_mask != want.relay_on_mask)
                  report("relay_on_mask", seen.relay_on_mask, want.relay_on_mask);
               if (seen.pump_state != want.pump_state)
                  report("pump_state", seen.pump_state, want.pump_state);
               if (seen.start_stage != want.start_stage)
                  report("start_stage", seen.start_stage, want.start_stage);
               if (seen.fault_event != want.fault_event)
                  report("fault_event", seen.fault_event, want.fault_event);
               if (seen.feedback_changed != want.feedback_changed)
                  report("feedback_changed", seen.feedback_changed,
                         want.feedback_changed);
            end
            results_seen++;
         end
         if (req.valid && req.ready) begin
            taken.kind               = req.kind;
            taken.channel_commands   = req.channel_commands;
            taken.channel_feedback   = req.channel_feedback;
            taken.relay_driver_error = req.relay_driver_error;
            expected_status.push_back(advance_starter(taken));
         end
         pending <= expected_status.size();
      end
   end

endmodule

>>> bench/staged_pump_start_sequencer_test.sv
`timescale 1ns / 1ps

module staged_pump_start_sequencer_test;
   import spp_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatches;
   int          pending;

   // sender burst bookkeeping
   int          burst_left = 0;

   // receiver stall pattern: rotate a 16-bit mask, reshuffle it now and then
   logic        rsp_take   = 1'b0;
   logic [15:0] stall_bits = '1;
   int          stall_age  = 0;

   spp_req_if pump_req ();
   spp_rsp_if pump_rsp ();

   assign pump_rsp.ready = rsp_take;

   staged_pump_start_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req         (pump_req),
      .rsp         (pump_rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spp_status_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req         (pump_req),
      .rsp         (pump_rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Receiver: about a third of the windows take every beat, the rest stall
   // on a random pattern. Keep a few ones in every pattern so it never locks.
   always @(posedge clock) begin
      if (stall_age == 47) begin
         stall_age = 0;
         if ($urandom_range(0, 2) == 0) stall_bits = '1;
         else stall_bits = 16'($urandom) | 16'h0101;
      end else begin
         stall_age++;
      end
      stall_bits = {stall_bits[0], stall_bits[15:1]};
      rsp_take  <= stall_bits[0];
   end

   // Hard stop in case the block hangs or a result never shows up.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Pack per-channel codes, channel 3 first, into one command field.
   function automatic logic [CMD_BITS-1:0] cmd_set(input logic [1:0] c3, input logic [1:0] c2,
                                                   input logic [1:0] c1, input logic [1:0] c0);
      return {c3, c2, c1, c0};
   endfunction

   function automatic req_item_type beat(input logic kind, input logic [CMD_BITS-1:0] cmds,
                                         input chan_type fb, input logic drv_err);
      req_item_type it;
      it.kind               = kind;
      it.channel_commands   = cmds;
      it.channel_feedback   = fb;
      it.relay_driver_error = drv_err;
      return it;
   endfunction

   // Random beat. Mostly ticks with healthy feedback so sequences reach the
   // running state; commands are rare and are mostly starts.
   function automatic req_item_type make_item();
      req_item_type it;
      int           roll;
      int           pick;
      it.kind             = KIND_TICK;
      it.channel_commands = CMD_BITS'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         it.kind = KIND_COMMAND;
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            // start: ON and NONE codes only, at least one ON
            for (int c = 0; c < CHANNELS; c++)
               it.channel_commands[2*c +: 2] = $urandom_range(0, 1) ? CMD_ON : CMD_NONE;
            it.channel_commands[2*$urandom_range(0, CHANNELS-1) +: 2] = CMD_ON;
         end else if (pick <= 7) begin
            // stop: any valid codes, at least one OFF
            for (int c = 0; c < CHANNELS; c++) begin
               case ($urandom_range(0, 2))
                  0:       it.channel_commands[2*c +: 2] = CMD_NONE;
                  1:       it.channel_commands[2*c +: 2] = CMD_ON;
                  default: it.channel_commands[2*c +: 2] = CMD_OFF;
               endcase
            end
            it.channel_commands[2*$urandom_range(0, CHANNELS-1) +: 2] = CMD_OFF;
         end else if (pick == 8) begin
            // broken command: poison one channel
            it.channel_commands[2*$urandom_range(0, CHANNELS-1) +: 2] = CMD_INVALID;
         end
      end
      roll = $urandom_range(0, 99);
      if (roll < 72) it.channel_feedback = '1;
      else if (roll < 86) it.channel_feedback = chan_type'((1 << $urandom_range(0, 3)) - 1);
      else it.channel_feedback = chan_type'($urandom);
      it.relay_driver_error = ($urandom_range(0, 99) < 5);
      return it;
   endfunction

   // Offer one beat and hold it until accepted. Open a new burst when the
   // old one is used up, usually after an idle gap.
   task automatic put_beat(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            pump_req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      pump_req.valid              <= 1'b1;
      pump_req.kind               <= it.kind;
      pump_req.channel_commands   <= it.channel_commands;
      pump_req.channel_feedback   <= it.channel_feedback;
      pump_req.relay_driver_error <= it.relay_driver_error;
      do @(posedge clock); while (!pump_req.ready);
      burst_left--;
   endtask

   // Drop valid and wait for every outstanding result. Check pending only once its
   // registered count in the checker includes the last accepted beat.
   task automatic drain();
      pump_req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup, then access; junk in the upper data bits must be dropped.
   task automatic write_reg(input logic [1:0] idx, input cfg_word_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_delays(input cfg_word_type s1, input cfg_word_type s2,
                             input cfg_word_type s3, input cfg_word_type mon);
      write_reg(REG_STAGE_ONE, s1);
      write_reg(REG_STAGE_TWO, s2);
      write_reg(REG_STAGE_THREE, s3);
      write_reg(REG_MONITOR, mon);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         // hold off once per phase until the block has answered everything
         if (i == count / 2) drain();
         put_beat(make_item());
      end
   endtask

   // Directed walk with every stage delay 2 ms and a 1 ms monitor interval,
   // so a monitor check lands on every tick inside a stage.
   task automatic run_directed();
      // stop first so the walk begins from stopped with cleared timers
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_OFF, CMD_OFF, CMD_OFF, CMD_OFF), '0, 1'b0));
      // tick carrying command bits, which must be ignored
      put_beat(beat(KIND_TICK, cmd_set(CMD_INVALID, CMD_INVALID, CMD_INVALID, CMD_INVALID),
                    '0, 1'b0));
      // all-invalid command, then an ON spoiled by one invalid code
      put_beat(beat(KIND_COMMAND,
                    cmd_set(CMD_INVALID, CMD_INVALID, CMD_INVALID, CMD_INVALID), '0, 1'b0));
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_NONE, CMD_NONE, CMD_INVALID, CMD_ON),
                    '0, 1'b0));
      // start with the driver failing: straight to fault, then stop out of fault
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_ON, CMD_NONE, CMD_NONE, CMD_NONE), '0, 1'b1));
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_OFF, CMD_NONE, CMD_NONE, CMD_NONE), '0, 1'b0));
      // clean start, and a second start while starting that must be ignored
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_ON, CMD_ON, CMD_ON, CMD_ON), '1, 1'b0));
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_NONE, CMD_NONE, CMD_NONE, CMD_ON), '1, 1'b0));
      // driver error on a tick that enables nothing is ignored
      put_beat(beat(KIND_TICK, '0, '1, 1'b1));
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      // stage 1: monitor check sees channel 0 off
      put_beat(beat(KIND_TICK, '0, '0, 1'b0));
      // start from fault; run to stage 2 and fail its relay enable
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_NONE, CMD_ON, CMD_NONE, CMD_NONE), '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '1, 1'b1));
      // full sequence into running
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_NONE, CMD_NONE, CMD_NONE, CMD_ON), '1, 1'b0));
      repeat (7) put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      // running check passes once, then fails on a missing top channel
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, 4'b0111, 1'b0));
      // stop out of running is covered by the random part; here check a stage
      // end that sees its own relay off
      put_beat(beat(KIND_COMMAND, cmd_set(CMD_NONE, CMD_NONE, CMD_NONE, CMD_ON), '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '1, 1'b0));
      put_beat(beat(KIND_TICK, '0, '0, 1'b0));
   endtask

   initial begin
      reset                       <= 1'b1;
      csr_psel                    <= 1'b0;
      csr_penable                 <= 1'b0;
      csr_pwrite                  <= 1'b0;
      csr_paddr                   <= '0;
      csr_pwdata                  <= '0;
      pump_req.valid              <= 1'b0;
      pump_req.kind               <= KIND_TICK;
      pump_req.channel_commands   <= '0;
      pump_req.channel_feedback   <= '0;
      pump_req.relay_driver_error <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // a few beats on the reset delays; stages are far too long to finish
      run_random(40);

      settle();
      set_delays(16'd2, 16'd2, 16'd2, 16'd1);
      run_directed();

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: set_delays(16'd1, 16'd1, 16'd1, 16'd1);
            // zero must behave as one millisecond
            1: set_delays(16'd0, 16'd0, 16'd0, 16'd0);
            // monitor interval longer than every stage delay: no mid-stage checks
            5: set_delays(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                          16'($urandom_range(1, 4)), 16'd24);
            default: set_delays(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                                16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)));
         endcase
         run_random(220);
      end

      // largest delays: sequences stay in stage 0
      settle();
      set_delays('1, '1, '1, '1);
      run_random(60);

      drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> staged_pump_start_sequencer.f
design/spp_pkg.sv
design/spp_channels.sv
design/spp_csr.sv
design/spp_core.sv
design/staged_pump_start_sequencer.sv
bench/spp_status_checker.sv
bench/staged_pump_start_sequencer_test.sv
